// ----- sv/etcc_pkg.sv -----
// shared types, request codes and constants for the edge table block
package etcc_pkg;

    // request codes
    localparam logic [2:0] REQ_ADD       = 3'd0;
    localparam logic [2:0] REQ_REM_EDGE  = 3'd1;
    localparam logic [2:0] REQ_REM_NODE  = 3'd2;
    localparam logic [2:0] REQ_CONTRACT  = 3'd3;
    localparam logic [2:0] REQ_READ_EDGE = 3'd4;
    localparam logic [2:0] REQ_READ_NODE = 3'd5;
    localparam logic [2:0] REQ_CHECK     = 3'd6;
    // unused code, always ignored
    localparam logic [2:0] REQ_BAD       = 3'd7;

    // node slots; node fields are 6 bits wide
    localparam int MAX_NODES = 64;
    localparam int CFG_W = 7;
    localparam logic [16:0] PROB_ONE = 17'h10000;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // request word
    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  node_a;
        logic [5:0]  node_b;
        logic [16:0] edge_prob_in;
    } t_req;

    // result word
    typedef struct packed {
        logic [16:0] edge_prob_out;
        logic [5:0]  node_degree_out;
        logic        node_present;
        logic        graph_connected;
        logic [6:0]  present_count;
        logic        status;
    } t_result;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_DISP,
        S_ADD_RD, S_ADD_CHK, S_ADD_MRG, S_RA_RD, S_RA_WR, S_RX_RD, S_RX_WR,
        S_RE_RD, S_RE_CHK, S_LA_RD, S_LA_WR, S_LB_RD, S_LB_WR,
        S_RN_RD, S_RN_CHK, S_RN_LRD, S_RN_LWR, S_RN_STEP, S_RN_IRD, S_RN_IWR,
        S_CN_RD, S_CN_CHK, S_CN_STEP,
        S_RDE_A, S_RDE_B, S_RDE_FIN, S_RDN_RD, S_RDN_FIN,
        S_CK_FRD, S_CK_FCHK, S_CK_POP, S_CK_POPW, S_CK_NRD, S_CK_NCHK,
        S_CK_PUSH2, S_CK_SCAN, S_CK_SCHK,
        S_DONE
    } t_state;

    // edge table address: pair a-b, pivot-j, a-j
    typedef enum logic [1:0] {EA_AB, EA_PJ, EA_AJ} t_eaddr;
    // edge table write data
    typedef enum logic [1:0] {EW_ZERO, EW_PROB, EW_MERGE} t_ewdata;
    // node info address
    typedef enum logic [1:0] {IA_A, IA_B, IA_J, IA_PIV} t_iaddr;
    // node info write data
    typedef enum logic [1:0] {IW_RAISE, IW_LOWER, IW_ZERO} t_iwdata;
    // pivot load source
    typedef enum logic [1:0] {PV_HOLD, PV_A, PV_B, PV_STK} t_piv;

    // controller to datapath commands
    typedef struct packed {
        logic    clr;
        logic    ld_req;
        logic    e_rd;
        logic    e_wr;
        t_eaddr  e_asel;
        t_ewdata e_wsel;
        logic    mul_ld;
        logic    p_from_e;
        logic    i_rd;
        logic    i_wr;
        t_iaddr  i_asel;
        t_iwdata i_wsel;
        logic    pt_dec;
        logic    j_clr;
        logic    j_inc;
        t_piv    piv_sel;
        logic    seen_clr;
        logic    seen_set;
        logic    sp_clr;
        logic    s_wr;
        logic    s_wsel_j;
        logic    s_pop;
        logic    flag_ld;
        logic    res_status;
        logic    res_prob;
        logic    res_node;
        logic    res_conn;
        logic    conn_val;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] req;
        logic pair_ok;
        logic a_ok;
        logic e_nz;
        logic i_nz;
        logic i_gt1;
        logic p_nz;
        logic pt_zero;
        logic j_eq_piv;
        logic j_last;
        logic j_lt_n;
        logic j_ok_add;
        logic j_seen;
        logic sp_zero;
        logic sp_room;
        logic clr_last;
    } t_stat;

endpackage

// ----- sv/etcc_dp.sv -----
// datapath: edge table, node info, walk stack, counters and result word
module etcc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etcc_pkg::t_req     i_req,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  etcc_pkg::t_cmd     i_cmd,
    output etcc_pkg::t_stat    o_stat,
    output etcc_pkg::t_result  o_result
);
    localparam int MAX_NODES = etcc_pkg::MAX_NODES;
    localparam int NW  = $clog2(MAX_NODES);
    localparam int JW  = NW + 1;
    localparam int IW  = NW + 1;
    localparam int TBL = MAX_NODES * (MAX_NODES + 1) / 2;
    localparam int TW  = $clog2(TBL);
    localparam int KW  = 2 * NW + 2;
    localparam int NCW = (JW > etcc_pkg::CFG_W) ? JW : etcc_pkg::CFG_W;

    // registers
    logic [6:0]           r_cfg;
    logic [2:0]           r_req_type;
    logic [5:0]           r_a, r_b;
    logic [16:0]          r_p;
    logic [NW-1:0]        r_piv;
    logic [JW-1:0]        r_j;
    logic [JW-1:0]        r_sp;
    logic [MAX_NODES-1:0] r_seen;
    logic                 r_flag;
    logic [IW-1:0]        r_ptotal;
    logic [33:0]          r_prod;
    logic [16:0]          r_edata;
    logic [IW-1:0]        r_idata;
    logic [NW-1:0]        r_sdata;
    logic [TW-1:0]        r_clr;
    etcc_pkg::t_result    r_res;

    // memories
    logic [16:0]   mem_edge  [TBL];
    logic [IW-1:0] mem_info  [MAX_NODES];
    logic [NW-1:0] mem_stack [MAX_NODES];

    logic [NCW-1:0] eff_n, cfg_ext;
    logic [NW-1:0]  a_idx, b_idx, j_idx;
    logic           a_ok, b_ok;
    logic [TW-1:0]  e_addr;
    logic [16:0]    e_wdata;
    logic           e_we;
    logic [NW-1:0]  i_addr;
    logic [IW-1:0]  i_wdata;
    logic           i_we;
    logic [16:0]    d_p, d_e, merge_val, p_sat;
    logic [34:0]    rnd;
    logic [JW-1:0]  sp_dec;

    // packed upper-triangular index of an unordered pair
    function automatic logic [TW-1:0] tri_idx(logic [NW-1:0] x, logic [NW-1:0] y);
        logic [NW-1:0] lo, hi;
        logic [KW-1:0] k;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        k = KW'(MAX_NODES) * KW'(lo) - ((KW'(lo) * (KW'(lo) + KW'(1))) >> 1) + KW'(hi);
        return TW'(k);
    endfunction

    // effective node count and range checks
    assign cfg_ext = NCW'(r_cfg);
    always_comb begin
        if (r_cfg == '0) begin
            eff_n = NCW'(1);
        end else if (cfg_ext > NCW'(MAX_NODES)) begin
            eff_n = NCW'(MAX_NODES);
        end else begin
            eff_n = cfg_ext;
        end
    end
    assign a_idx = NW'(r_a);
    assign b_idx = NW'(r_b);
    assign j_idx = r_j[NW-1:0];
    assign a_ok  = NCW'(r_a) < eff_n;
    assign b_ok  = NCW'(r_b) < eff_n;
    assign sp_dec = r_sp - JW'(1);

    // merge 1-(1-p)(1-q), rounded half up
    assign d_p = etcc_pkg::PROB_ONE - r_p;
    assign d_e = etcc_pkg::PROB_ONE - r_edata;
    assign rnd = {1'b0, r_prod} + 35'd32768;
    assign merge_val = etcc_pkg::PROB_ONE - rnd[32:16];
    assign p_sat = (i_req.edge_prob_in > etcc_pkg::PROB_ONE) ? etcc_pkg::PROB_ONE
                                                             : i_req.edge_prob_in;

    // edge table address and data
    always_comb begin
        case (i_cmd.e_asel)
            etcc_pkg::EA_PJ: e_addr = tri_idx(r_piv, j_idx);
            etcc_pkg::EA_AJ: e_addr = tri_idx(a_idx, j_idx);
            default:         e_addr = tri_idx(a_idx, b_idx);
        endcase
        if (i_cmd.clr) begin
            e_addr = r_clr;
        end
        case (i_cmd.e_wsel)
            etcc_pkg::EW_PROB:  e_wdata = r_p;
            etcc_pkg::EW_MERGE: e_wdata = merge_val;
            default:            e_wdata = '0;
        endcase
        if (i_cmd.clr) begin
            e_wdata = '0;
        end
        e_we = i_cmd.e_wr | i_cmd.clr;
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            mem_edge[e_addr] <= e_wdata;
        end
        if (i_cmd.e_rd) begin
            r_edata <= mem_edge[e_addr];
        end
    end

    // node info address and data
    always_comb begin
        case (i_cmd.i_asel)
            etcc_pkg::IA_B:   i_addr = b_idx;
            etcc_pkg::IA_J:   i_addr = j_idx;
            etcc_pkg::IA_PIV: i_addr = r_piv;
            default:          i_addr = a_idx;
        endcase
        case (i_cmd.i_wsel)
            etcc_pkg::IW_RAISE: i_wdata = (r_idata == '0) ? IW'(2) : r_idata + IW'(1);
            etcc_pkg::IW_LOWER: i_wdata = (r_idata > IW'(1)) ? r_idata - IW'(1) : r_idata;
            default:            i_wdata = '0;
        endcase
        i_we = i_cmd.i_wr;
        if (i_cmd.clr) begin
            i_addr  = r_clr[NW-1:0];
            i_wdata = '0;
            i_we    = (r_clr < TW'(MAX_NODES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_info[i_addr] <= i_wdata;
        end
        if (i_cmd.i_rd) begin
            r_idata <= mem_info[i_addr];
        end
    end

    // walk stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.s_wr) begin
            mem_stack[r_sp[NW-1:0]] <= i_cmd.s_wsel_j ? j_idx : r_piv;
        end
        if (i_cmd.s_pop) begin
            r_sdata <= mem_stack[sp_dec[NW-1:0]];
        end
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= etcc_pkg::CFG_RESET;
            r_ptotal <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + TW'(1);
            end
            if (i_cmd.i_wr && i_cmd.i_wsel == etcc_pkg::IW_RAISE && r_idata == '0) begin
                r_ptotal <= r_ptotal + IW'(1);
            end else if (i_cmd.pt_dec && r_idata != '0 && r_ptotal != '0) begin
                r_ptotal <= r_ptotal - IW'(1);
            end
        end
    end

    // request, counters and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_req_type <= i_req.req_type;
            r_a        <= i_req.node_a;
            r_b        <= i_req.node_b;
            r_p        <= p_sat;
            r_res      <= '0;
        end
        if (i_cmd.p_from_e) begin
            r_p <= r_edata;
        end
        if (i_cmd.mul_ld) begin
            r_prod <= d_p * d_e;
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + JW'(1);
        end
        case (i_cmd.piv_sel)
            etcc_pkg::PV_A:   r_piv <= a_idx;
            etcc_pkg::PV_B:   r_piv <= b_idx;
            etcc_pkg::PV_STK: r_piv <= r_sdata;
            default:          r_piv <= r_piv;
        endcase
        if (i_cmd.seen_clr) begin
            r_seen <= '0;
        end else if (i_cmd.seen_set) begin
            r_seen[j_idx] <= 1'b1;
        end
        if (i_cmd.sp_clr) begin
            r_sp <= '0;
        end else if (i_cmd.s_wr) begin
            r_sp <= r_sp + JW'(1);
        end else if (i_cmd.s_pop) begin
            r_sp <= sp_dec;
        end
        if (i_cmd.flag_ld) begin
            r_flag <= (r_idata > IW'(1));
        end
        // result fields
        if (i_cmd.res_status) begin
            r_res.status <= 1'b1;
        end
        if (i_cmd.res_prob) begin
            r_res.edge_prob_out <= (r_flag && r_idata > IW'(1)) ? r_edata : '0;
        end
        if (i_cmd.res_node) begin
            r_res.node_degree_out <= (r_idata != '0) ? 6'(r_idata - IW'(1)) : '0;
            r_res.node_present    <= (r_idata != '0);
        end
        if (i_cmd.res_conn) begin
            r_res.graph_connected <= i_cmd.conn_val;
        end
    end

    // status to controller
    always_comb begin
        o_stat.req      = r_req_type;
        o_stat.pair_ok  = a_ok && b_ok && (r_a != r_b);
        o_stat.a_ok     = a_ok;
        o_stat.e_nz     = (r_edata != '0);
        o_stat.i_nz     = (r_idata != '0);
        o_stat.i_gt1    = (r_idata > IW'(1));
        o_stat.p_nz     = (r_p != '0);
        o_stat.pt_zero  = (r_ptotal == '0);
        o_stat.j_eq_piv = (j_idx == r_piv);
        o_stat.j_last   = (r_j == JW'(MAX_NODES - 1));
        o_stat.j_lt_n   = (NCW'(r_j) < eff_n);
        o_stat.j_ok_add = (NCW'(r_j) < eff_n) && (NCW'(r_j) != NCW'(r_a));
        o_stat.j_seen   = r_seen[j_idx];
        o_stat.sp_zero  = (r_sp == '0);
        o_stat.sp_room  = ((JW + 1)'(r_sp) + (JW + 1)'(2) <= (JW + 1)'(MAX_NODES));
        o_stat.clr_last = (r_clr == TW'(TBL - 1));
    end

    // result word, count taken live
    always_comb begin
        o_result = r_res;
        o_result.present_count = 7'(r_ptotal);
    end

endmodule

// ----- sv/etcc_ctrl.sv -----
// controller: request sequencer state machine
module etcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  etcc_pkg::t_stat  i_stat,
    output etcc_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);
    etcc_pkg::t_state r_state, n_state;
    logic             r_con, n_con;
    etcc_pkg::t_eaddr add_asel;
    etcc_pkg::t_iaddr add_xsel;
    etcc_pkg::t_state add_ret;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etcc_pkg::S_CLEAR;
            r_con   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_con   <= n_con;
        end
    end

    // add edge targets a-b normally, a-j while contracting
    assign add_asel = r_con ? etcc_pkg::EA_AJ : etcc_pkg::EA_AB;
    assign add_xsel = r_con ? etcc_pkg::IA_J : etcc_pkg::IA_B;
    assign add_ret  = r_con ? etcc_pkg::S_CN_STEP : etcc_pkg::S_DONE;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_con    = r_con;
        o_cmd    = '0;
        o_busy   = (r_state != etcc_pkg::S_IDLE);
        o_strobe = 1'b0;
        case (r_state)
            etcc_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = etcc_pkg::S_IDLE;
            end
            etcc_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_req = 1'b1;
                    n_con = 1'b0;
                    n_state = etcc_pkg::S_DISP;
                end
            end
            etcc_pkg::S_DISP: begin
                case (i_stat.req)
                    etcc_pkg::REQ_ADD: begin
                        if (i_stat.pair_ok) n_state = etcc_pkg::S_ADD_RD;
                        else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_REM_EDGE: begin
                        if (i_stat.pair_ok) n_state = etcc_pkg::S_RE_RD;
                        else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_REM_NODE: begin
                        if (i_stat.a_ok) begin
                            o_cmd.piv_sel = etcc_pkg::PV_A;
                            o_cmd.j_clr = 1'b1;
                            n_state = etcc_pkg::S_RN_RD;
                        end else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_CONTRACT: begin
                        if (i_stat.pair_ok) begin
                            o_cmd.piv_sel = etcc_pkg::PV_B;
                            o_cmd.j_clr = 1'b1;
                            n_con = 1'b1;
                            n_state = etcc_pkg::S_CN_RD;
                        end else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_READ_EDGE: begin
                        if (i_stat.pair_ok) n_state = etcc_pkg::S_RDE_A;
                        else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_READ_NODE: begin
                        if (i_stat.a_ok) n_state = etcc_pkg::S_RDN_RD;
                        else begin
                            o_cmd.res_status = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end
                    end
                    etcc_pkg::REQ_CHECK: begin
                        if (i_stat.pt_zero) begin
                            o_cmd.res_conn = 1'b1;
                            o_cmd.conn_val = 1'b1;
                            n_state = etcc_pkg::S_DONE;
                        end else begin
                            o_cmd.j_clr = 1'b1;
                            o_cmd.seen_clr = 1'b1;
                            o_cmd.sp_clr = 1'b1;
                            n_state = etcc_pkg::S_CK_FRD;
                        end
                    end
                    default: begin
                        o_cmd.res_status = 1'b1;
                        n_state = etcc_pkg::S_DONE;
                    end
                endcase
            end
            // add edge, merging into an existing one if present
            etcc_pkg::S_ADD_RD: begin
                o_cmd.e_rd = 1'b1;
                o_cmd.e_asel = add_asel;
                n_state = etcc_pkg::S_ADD_CHK;
            end
            etcc_pkg::S_ADD_CHK: begin
                if (i_stat.e_nz) begin
                    o_cmd.mul_ld = 1'b1;
                    n_state = etcc_pkg::S_ADD_MRG;
                end else if (i_stat.p_nz) begin
                    o_cmd.e_wr = 1'b1;
                    o_cmd.e_asel = add_asel;
                    o_cmd.e_wsel = etcc_pkg::EW_PROB;
                    n_state = etcc_pkg::S_RA_RD;
                end else begin
                    n_state = add_ret;
                end
            end
            etcc_pkg::S_ADD_MRG: begin
                o_cmd.e_wr = 1'b1;
                o_cmd.e_asel = add_asel;
                o_cmd.e_wsel = etcc_pkg::EW_MERGE;
                n_state = add_ret;
            end
            etcc_pkg::S_RA_RD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                n_state = etcc_pkg::S_RA_WR;
            end
            etcc_pkg::S_RA_WR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                o_cmd.i_wsel = etcc_pkg::IW_RAISE;
                n_state = etcc_pkg::S_RX_RD;
            end
            etcc_pkg::S_RX_RD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = add_xsel;
                n_state = etcc_pkg::S_RX_WR;
            end
            etcc_pkg::S_RX_WR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = add_xsel;
                o_cmd.i_wsel = etcc_pkg::IW_RAISE;
                n_state = add_ret;
            end
            // remove edge
            etcc_pkg::S_RE_RD: begin
                o_cmd.e_rd = 1'b1;
                o_cmd.e_asel = etcc_pkg::EA_AB;
                n_state = etcc_pkg::S_RE_CHK;
            end
            etcc_pkg::S_RE_CHK: begin
                if (i_stat.e_nz) begin
                    o_cmd.e_wr = 1'b1;
                    o_cmd.e_asel = etcc_pkg::EA_AB;
                    o_cmd.e_wsel = etcc_pkg::EW_ZERO;
                    n_state = etcc_pkg::S_LA_RD;
                end else begin
                    n_state = etcc_pkg::S_DONE;
                end
            end
            etcc_pkg::S_LA_RD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                n_state = etcc_pkg::S_LA_WR;
            end
            etcc_pkg::S_LA_WR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                o_cmd.i_wsel = etcc_pkg::IW_LOWER;
                n_state = etcc_pkg::S_LB_RD;
            end
            etcc_pkg::S_LB_RD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_B;
                n_state = etcc_pkg::S_LB_WR;
            end
            etcc_pkg::S_LB_WR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_B;
                o_cmd.i_wsel = etcc_pkg::IW_LOWER;
                n_state = etcc_pkg::S_DONE;
            end
            // remove pivot node: clear its row, then its info word
            etcc_pkg::S_RN_RD: begin
                if (i_stat.j_eq_piv) n_state = etcc_pkg::S_RN_STEP;
                else begin
                    o_cmd.e_rd = 1'b1;
                    o_cmd.e_asel = etcc_pkg::EA_PJ;
                    n_state = etcc_pkg::S_RN_CHK;
                end
            end
            etcc_pkg::S_RN_CHK: begin
                if (i_stat.e_nz) begin
                    o_cmd.e_wr = 1'b1;
                    o_cmd.e_asel = etcc_pkg::EA_PJ;
                    o_cmd.e_wsel = etcc_pkg::EW_ZERO;
                    n_state = etcc_pkg::S_RN_LRD;
                end else begin
                    n_state = etcc_pkg::S_RN_STEP;
                end
            end
            etcc_pkg::S_RN_LRD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_J;
                n_state = etcc_pkg::S_RN_LWR;
            end
            etcc_pkg::S_RN_LWR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_J;
                o_cmd.i_wsel = etcc_pkg::IW_LOWER;
                n_state = etcc_pkg::S_RN_STEP;
            end
            etcc_pkg::S_RN_STEP: begin
                if (i_stat.j_last) n_state = etcc_pkg::S_RN_IRD;
                else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = etcc_pkg::S_RN_RD;
                end
            end
            etcc_pkg::S_RN_IRD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_PIV;
                n_state = etcc_pkg::S_RN_IWR;
            end
            etcc_pkg::S_RN_IWR: begin
                o_cmd.i_wr = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_PIV;
                o_cmd.i_wsel = etcc_pkg::IW_ZERO;
                o_cmd.pt_dec = 1'b1;
                n_state = etcc_pkg::S_DONE;
            end
            // contraction: fold row of b into a, then remove b
            etcc_pkg::S_CN_RD: begin
                if (i_stat.j_eq_piv) n_state = etcc_pkg::S_CN_STEP;
                else begin
                    o_cmd.e_rd = 1'b1;
                    o_cmd.e_asel = etcc_pkg::EA_PJ;
                    n_state = etcc_pkg::S_CN_CHK;
                end
            end
            etcc_pkg::S_CN_CHK: begin
                if (i_stat.e_nz && i_stat.j_ok_add) begin
                    o_cmd.p_from_e = 1'b1;
                    n_state = etcc_pkg::S_ADD_RD;
                end else begin
                    n_state = etcc_pkg::S_CN_STEP;
                end
            end
            etcc_pkg::S_CN_STEP: begin
                if (i_stat.j_last) begin
                    o_cmd.j_clr = 1'b1;
                    n_con = 1'b0;
                    n_state = etcc_pkg::S_RN_RD;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = etcc_pkg::S_CN_RD;
                end
            end
            // read edge
            etcc_pkg::S_RDE_A: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                n_state = etcc_pkg::S_RDE_B;
            end
            etcc_pkg::S_RDE_B: begin
                o_cmd.flag_ld = 1'b1;
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_B;
                o_cmd.e_rd = 1'b1;
                o_cmd.e_asel = etcc_pkg::EA_AB;
                n_state = etcc_pkg::S_RDE_FIN;
            end
            etcc_pkg::S_RDE_FIN: begin
                o_cmd.res_prob = 1'b1;
                n_state = etcc_pkg::S_DONE;
            end
            // read node
            etcc_pkg::S_RDN_RD: begin
                o_cmd.i_rd = 1'b1;
                o_cmd.i_asel = etcc_pkg::IA_A;
                n_state = etcc_pkg::S_RDN_FIN;
            end
            etcc_pkg::S_RDN_FIN: begin
                o_cmd.res_node = 1'b1;
                n_state = etcc_pkg::S_DONE;
            end
            // connectivity: find lowest present node
            etcc_pkg::S_CK_FRD: begin
                if (!i_stat.j_lt_n) begin
                    o_cmd.j_clr = 1'b1;
                    n_state = etcc_pkg::S_CK_SCAN;
                end else begin
                    o_cmd.i_rd = 1'b1;
                    o_cmd.i_asel = etcc_pkg::IA_J;
                    n_state = etcc_pkg::S_CK_FCHK;
                end
            end
            etcc_pkg::S_CK_FCHK: begin
                if (i_stat.i_nz) begin
                    o_cmd.seen_set = 1'b1;
                    o_cmd.s_wr = 1'b1;
                    o_cmd.s_wsel_j = 1'b1;
                    n_state = etcc_pkg::S_CK_POP;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = etcc_pkg::S_CK_FRD;
                end
            end
            // depth-first walk
            etcc_pkg::S_CK_POP: begin
                if (i_stat.sp_zero) begin
                    o_cmd.j_clr = 1'b1;
                    n_state = etcc_pkg::S_CK_SCAN;
                end else begin
                    o_cmd.s_pop = 1'b1;
                    n_state = etcc_pkg::S_CK_POPW;
                end
            end
            etcc_pkg::S_CK_POPW: begin
                o_cmd.piv_sel = etcc_pkg::PV_STK;
                o_cmd.j_clr = 1'b1;
                n_state = etcc_pkg::S_CK_NRD;
            end
            etcc_pkg::S_CK_NRD: begin
                if (!i_stat.j_lt_n) n_state = etcc_pkg::S_CK_POP;
                else if (i_stat.j_eq_piv || i_stat.j_seen) o_cmd.j_inc = 1'b1;
                else begin
                    o_cmd.e_rd = 1'b1;
                    o_cmd.e_asel = etcc_pkg::EA_PJ;
                    n_state = etcc_pkg::S_CK_NCHK;
                end
            end
            etcc_pkg::S_CK_NCHK: begin
                if (i_stat.e_nz) begin
                    if (i_stat.sp_room) begin
                        o_cmd.seen_set = 1'b1;
                        o_cmd.s_wr = 1'b1;
                        n_state = etcc_pkg::S_CK_PUSH2;
                    end else begin
                        n_state = etcc_pkg::S_CK_POP;
                    end
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = etcc_pkg::S_CK_NRD;
                end
            end
            etcc_pkg::S_CK_PUSH2: begin
                o_cmd.s_wr = 1'b1;
                o_cmd.s_wsel_j = 1'b1;
                n_state = etcc_pkg::S_CK_POP;
            end
            // look for an unreached node with edges
            etcc_pkg::S_CK_SCAN: begin
                if (!i_stat.j_lt_n) begin
                    o_cmd.res_conn = 1'b1;
                    o_cmd.conn_val = 1'b1;
                    n_state = etcc_pkg::S_DONE;
                end else if (i_stat.j_seen) begin
                    o_cmd.j_inc = 1'b1;
                end else begin
                    o_cmd.i_rd = 1'b1;
                    o_cmd.i_asel = etcc_pkg::IA_J;
                    n_state = etcc_pkg::S_CK_SCHK;
                end
            end
            etcc_pkg::S_CK_SCHK: begin
                if (i_stat.i_gt1) begin
                    o_cmd.res_conn = 1'b1;
                    o_cmd.conn_val = 1'b0;
                    n_state = etcc_pkg::S_DONE;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = etcc_pkg::S_CK_SCAN;
                end
            end
            etcc_pkg::S_DONE: begin
                o_strobe = 1'b1;
                n_state = etcc_pkg::S_IDLE;
            end
            default: begin
                n_state = etcc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/edge_table_with_connectivity_check.sv -----
// top level: edge probability table with connectivity check
// One request word is taken when start is high and busy is low; exactly one result word
// follows on o_result, marked by o_result_strobe for a single cycle, and it cannot be held
// off. After reset a clearing pass over all MAX_NODES*(MAX_NODES+1)/2 table entries
// (2080 at 64 nodes) zeroes the edge table and node info while busy stays high; the node
// count register may be written during it. All table and node info accesses go through
// one single-ported memory each: read node reads one info word, read edge both info words
// and the edge, add and remove edge read the edge and, where it is created or removed,
// update both info words, remove node probes every slot of the node's row, contraction
// scans the row of the merged node, folds its edges in and then removes it, and the
// connectivity check rescans a table row after every step of its depth-first walk.
module edge_table_with_connectivity_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  etcc_pkg::t_req     i_req,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    output logic               o_result_strobe,
    output etcc_pkg::t_result  o_result
);
    etcc_pkg::t_cmd  cmd;
    etcc_pkg::t_stat stat;
    logic            ctrl_busy;

    // sequencer
    etcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy),
        .o_strobe (o_result_strobe)
    );

    // storage and arithmetic
    etcc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    // no word taken while in reset
    assign busy = ctrl_busy | ~i_rst_n;

    // a result word lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // an ignored request reports nothing else
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.status) |->
            (!o_result.graph_connected && !o_result.node_present &&
             o_result.edge_prob_out == '0))
        else $error("ignored request carries data");

    // table and walk memories are never written together with a clearing step
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> (!cmd.e_wr && !cmd.i_wr && !cmd.s_wr && !o_result_strobe))
        else $error("access during clearing pass");

endmodule
